FILE: rtl/bdal_pkg.sv
// Shared constants, codes and types of the buffer directory allocate/lookup unit.
package bdal_pkg;

    localparam int ENTRIES  = 32;
    localparam int DISK_SIZE = 8192;
    localparam int AGE_BITS = 16;

    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int TAG_W   = 16;
    localparam int OP_W    = 2;
    localparam int STS_W   = 2;
    localparam int EIDX_W  = 5;

    localparam logic [TAG_W:0]    DISK_LIMIT = (TAG_W + 1)'(DISK_SIZE);
    localparam logic [AGE_BITS-1:0] AGE_MAX  = '1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_DIRTY  = 2'd2;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd3;

    // Status codes
    localparam logic [STS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STS_W-1:0] STS_OUTOFBOUND = 2'd1;
    localparam logic [STS_W-1:0] STS_NOTINBUF  = 2'd2;

    // Search word that walks the cell chain, one cell per cycle.
    typedef struct packed {
        logic                valid;
        logic [TAG_W-1:0]    key;
        logic                free_found;
        logic [IDX_W-1:0]    free_idx;
        logic                match_found;
        logic [IDX_W-1:0]    match_idx;
        logic                best_set;
        logic [AGE_BITS-1:0] best_age;
        logic [IDX_W-1:0]    best_idx;
        logic                best_dirty;
        logic [TAG_W-1:0]    best_tag;
    } scan_t;

    // Update broadcast to every cell.
    typedef struct packed {
        logic             install;
        logic             set_dirty;
        logic             tick;
        logic [IDX_W-1:0] target;
        logic [TAG_W-1:0] tag;
    } cmd_t;

endpackage

FILE: rtl/buffer_directory_alloc_lookup_unit.sv
// Top level of the buffer directory: command port, cell chain and result register.
//
// Usage: present op and block_number with start high while busy is low; the
// word is taken at that clock edge. Each word gives exactly one result, shown
// on status, entry_index, writeback_valid and writeback_block for one cycle
// with done high. The receiver cannot stall; results must be taken as shown.
//
// Timing of results:
//  - age tick and out-of-bound requests answer in the cycle after acceptance
//    and leave busy low, so the next word may follow at once.
//  - allocate, lookup and set dirty register the word, then send a search
//    word down the chain of ENTRIES cells, one cell per cycle; the result
//    is registered when the word leaves the last cell, and busy stays high
//    until that result is registered, so the next word waits.
//  - the directory update (install or dirty mark) is applied at the same
//    edge that registers the result.
//
// Reset (rst_n low, asynchronous): all entries free and clean, tags all
// ones, ages zero; no result pending and busy low.
module buffer_directory_alloc_lookup_unit
    import bdal_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   op,
    input  logic [TAG_W-1:0]  block_number,
    output logic              done,
    output logic [STS_W-1:0]  status,
    output logic [EIDX_W-1:0] entry_index,
    output logic              writeback_valid,
    output logic [TAG_W-1:0]  writeback_block
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic               state_reg, state_next;
    logic               launch_reg, launch_next;
    logic [OP_W-1:0]    op_reg, op_next;
    logic [TAG_W-1:0]   blk_reg, blk_next;

    logic               done_reg, done_next;
    logic [STS_W-1:0]   status_reg, status_next;
    logic [EIDX_W-1:0]  eidx_reg, eidx_next;
    logic               wbv_reg, wbv_next;
    logic [TAG_W-1:0]   wbb_reg, wbb_next;

    logic               accept;
    logic               out_of_bound;
    scan_t              chain [ENTRIES+1];
    scan_t              tail;
    cmd_t               cmd;
    logic [IDX_W-1:0]   pick;

    assign accept       = start && (state_reg == ST_IDLE);
    assign out_of_bound = ({1'b0, block_number} >= DISK_LIMIT);
    assign busy         = (state_reg != ST_IDLE);

    // Launch word: empty search carrying the key
    always_comb
    begin
        chain[0]       = '0;
        chain[0].valid = launch_reg;
        chain[0].key   = blk_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_cell
            bdal_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .my_idx   (IDX_W'(gi)),
                .scan_in  (chain[gi]),
                .cmd      (cmd),
                .scan_out (chain[gi+1])
            );
        end
    endgenerate

    assign tail = chain[ENTRIES];
    // Allocation victim: first free entry, else the oldest
    assign pick = tail.free_found ? tail.free_idx : tail.best_idx;

    // Control, broadcast command and result
    always_comb
    begin
        state_next  = state_reg;
        launch_next = 1'b0;
        op_next     = op_reg;
        blk_next    = blk_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        eidx_next   = eidx_reg;
        wbv_next    = wbv_reg;
        wbb_next    = wbb_reg;
        cmd         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == OP_TICK)
                    begin
                        // Age every occupied entry now; answer at once
                        cmd.tick    = 1'b1;
                        done_next   = 1'b1;
                        status_next = STS_OK;
                        eidx_next   = '0;
                        wbv_next    = 1'b0;
                        wbb_next    = '0;
                    end
                    else if (out_of_bound)
                    begin
                        done_next   = 1'b1;
                        status_next = STS_OUTOFBOUND;
                        eidx_next   = '0;
                        wbv_next    = 1'b0;
                        wbb_next    = '0;
                    end
                    else
                    begin
                        op_next     = op;
                        blk_next    = block_number;
                        launch_next = 1'b1;
                        state_next  = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // Hold until the search word leaves the last cell
                if (tail.valid)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    wbv_next   = 1'b0;
                    wbb_next   = '0;
                    if (op_reg == OP_ALLOC)
                    begin
                        cmd.install = 1'b1;
                        cmd.target  = pick;
                        cmd.tag     = blk_reg;
                        status_next = STS_OK;
                        eidx_next   = EIDX_W'(pick);
                        if (!tail.free_found && tail.best_dirty)
                        begin
                            wbv_next = 1'b1;
                            wbb_next = tail.best_tag;
                        end
                    end
                    else if (tail.match_found)
                    begin
                        cmd.set_dirty = (op_reg == OP_DIRTY);
                        cmd.target    = tail.match_idx;
                        status_next   = STS_OK;
                        eidx_next     = EIDX_W'(tail.match_idx);
                    end
                    else
                    begin
                        status_next = STS_NOTINBUF;
                        eidx_next   = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            launch_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        blk_reg    <= blk_next;
        status_reg <= status_next;
        eidx_reg   <= eidx_next;
        wbv_reg    <= wbv_next;
        wbb_reg    <= wbb_next;
    end

    assign done            = done_reg;
    assign status          = status_reg;
    assign entry_index     = eidx_reg;
    assign writeback_valid = wbv_reg;
    assign writeback_block = wbb_reg;

endmodule

FILE: rtl/bdal_cell.sv
// One directory entry: holds its flags, tag and age, and advances the search word.
module bdal_cell
    import bdal_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] my_idx,
    input  scan_t            scan_in,
    input  cmd_t             cmd,
    output scan_t            scan_out
);

    logic                occupied_reg, occupied_next;
    logic                dirty_reg, dirty_next;
    logic [TAG_W-1:0]    tag_reg, tag_next;
    logic [AGE_BITS-1:0] age_reg, age_next;
    scan_t               scan_reg, scan_next;
    logic                hit_target;

    assign hit_target = (cmd.target == my_idx);

    // Entry update: tick, install, mark dirty
    always_comb
    begin
        occupied_next = occupied_reg;
        dirty_next    = dirty_reg;
        tag_next      = tag_reg;
        age_next      = age_reg;
        if (cmd.tick && occupied_reg && (age_reg != AGE_MAX))
        begin
            age_next = age_reg + AGE_BITS'(1);
        end
        if (cmd.install && hit_target)
        begin
            occupied_next = 1'b1;
            dirty_next    = 1'b0;
            tag_next      = cmd.tag;
            age_next      = '0;
        end
        if (cmd.set_dirty && hit_target)
        begin
            dirty_next = 1'b1;
        end
    end

    // Search step: first free, first match, oldest (first on ties)
    always_comb
    begin
        scan_next = scan_in;
        if (!scan_in.free_found && !occupied_reg)
        begin
            scan_next.free_found = 1'b1;
            scan_next.free_idx   = my_idx;
        end
        if (!scan_in.match_found && occupied_reg && (tag_reg == scan_in.key))
        begin
            scan_next.match_found = 1'b1;
            scan_next.match_idx   = my_idx;
        end
        if (!scan_in.best_set || (age_reg > scan_in.best_age))
        begin
            scan_next.best_set   = 1'b1;
            scan_next.best_age   = age_reg;
            scan_next.best_idx   = my_idx;
            scan_next.best_dirty = dirty_reg;
            scan_next.best_tag   = tag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupied_reg <= 1'b0;
            dirty_reg    <= 1'b0;
            tag_reg      <= '1;
            age_reg      <= '0;
            scan_reg     <= '0;
        end
        else
        begin
            occupied_reg <= occupied_next;
            dirty_reg    <= dirty_next;
            tag_reg      <= tag_next;
            age_reg      <= age_next;
            scan_reg     <= scan_next;
        end
    end

    assign scan_out = scan_reg;

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the buffer directory allocate/lookup unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bdal_pkg::*;

    // Run limit in clock cycles, several times the slowest legal run: some 1450
    // words, each a full search of the chain, plus the longest sender gap.
    localparam int CYCLE_LIMIT = 400_000;
    localparam int RANDOM_WORDS = 1430;
    localparam int MAX_GAP = 17;

    // One result word as the block reports it.
    typedef struct packed {
        logic [STS_W-1:0]  status;
        logic [EIDX_W-1:0] idx;
        logic              wbv;
        logic [TAG_W-1:0]  wbb;
    } dir_result_t;

    // One row of the directed plan. When known is set, the typed result is
    // the expectation; otherwise the directory model supplies it.
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [TAG_W-1:0] blk;
        logic             known;
        dir_result_t      res;
    } plan_row_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [OP_W-1:0]   op;
    logic [TAG_W-1:0]  block_number;
    logic              done;
    logic [STS_W-1:0]  status;
    logic [EIDX_W-1:0] entry_index;
    logic              writeback_valid;
    logic [TAG_W-1:0]  writeback_block;

    buffer_directory_alloc_lookup_unit DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .op              (op),
        .block_number    (block_number),
        .done            (done),
        .status          (status),
        .entry_index     (entry_index),
        .writeback_valid (writeback_valid),
        .writeback_block (writeback_block)
    );

    // Directory model: our own copy of every entry.
    logic                occ     [ENTRIES];
    logic                dirt    [ENTRIES];
    logic [TAG_W-1:0]    tag     [ENTRIES];
    logic [AGE_BITS-1:0] age     [ENTRIES];

    // Results still owed by the block, oldest first.
    dir_result_t pending_results [$];

    int errors = 0;
    int cycles = 0;
    int n_words = 0;
    int n_allocs = 0;
    int n_writebacks = 0;
    int n_hits = 0;
    int n_misses = 0;
    int n_oob = 0;
    bit no_gaps = 1'b0;

    // Directed plan: boundaries of the block number, every operation, misses
    // on an empty directory, a duplicate install and the dirty mark.
    localparam int PLAN_ROWS = 20;
    plan_row_t plan [PLAN_ROWS] = '{
        '{OP_LOOKUP, 16'd0,     1'b1, '{STS_NOTINBUF,   5'd0, 1'b0, 16'd0}},
        '{OP_DIRTY,  16'd5,     1'b1, '{STS_NOTINBUF,   5'd0, 1'b0, 16'd0}},
        '{OP_TICK,   16'hFFFF,  1'b1, '{STS_OK,         5'd0, 1'b0, 16'd0}},
        '{OP_ALLOC,  16'd8192,  1'b1, '{STS_OUTOFBOUND, 5'd0, 1'b0, 16'd0}},
        '{OP_LOOKUP, 16'hFFFF,  1'b1, '{STS_OUTOFBOUND, 5'd0, 1'b0, 16'd0}},
        '{OP_DIRTY,  16'd8192,  1'b1, '{STS_OUTOFBOUND, 5'd0, 1'b0, 16'd0}},
        '{OP_ALLOC,  16'd0,     1'b1, '{STS_OK,         5'd0, 1'b0, 16'd0}},
        '{OP_ALLOC,  16'd8191,  1'b1, '{STS_OK,         5'd1, 1'b0, 16'd0}},
        '{OP_LOOKUP, 16'd8191,  1'b1, '{STS_OK,         5'd1, 1'b0, 16'd0}},
        '{OP_ALLOC,  16'd0,     1'b1, '{STS_OK,         5'd2, 1'b0, 16'd0}},
        '{OP_LOOKUP, 16'd0,     1'b1, '{STS_OK,         5'd0, 1'b0, 16'd0}},
        '{OP_DIRTY,  16'd0,     1'b1, '{STS_OK,         5'd0, 1'b0, 16'd0}},
        '{OP_TICK,   16'd0,     1'b1, '{STS_OK,         5'd0, 1'b0, 16'd0}},
        '{OP_DIRTY,  16'd8191,  1'b1, '{STS_OK,         5'd1, 1'b0, 16'd0}},
        '{OP_LOOKUP, 16'd4660,  1'b1, '{STS_NOTINBUF,   5'd0, 1'b0, 16'd0}},
        '{OP_ALLOC,  16'h5555,  1'b1, '{STS_OUTOFBOUND, 5'd0, 1'b0, 16'd0}},
        '{OP_ALLOC,  16'h0AAA,  1'b1, '{STS_OK,         5'd3, 1'b0, 16'd0}},
        '{OP_LOOKUP, 16'h0AAA,  1'b0, '0},
        '{OP_ALLOC,  16'h1555,  1'b0, '0},
        '{OP_TICK,   16'hAAAA,  1'b0, '0}
    };

    // Advance the directory model by one word and return the result it owes.
    function automatic dir_result_t apply_word(input logic [OP_W-1:0] o,
                                               input logic [TAG_W-1:0] b);
        dir_result_t r;
        int pick;
        r = '0;
        r.status = STS_OK;
        pick = -1;
        if (o == OP_TICK) begin
            // Age every occupied entry, holding at the ceiling.
            for (int i = 0; i < ENTRIES; i++)
                if (occ[i] && age[i] != AGE_MAX)
                    age[i] = age[i] + AGE_BITS'(1);
        end else if (int'(b) >= DISK_SIZE) begin
            r.status = STS_OUTOFBOUND;
        end else if (o == OP_ALLOC) begin
            for (int i = 0; i < ENTRIES; i++)
                if (pick < 0 && !occ[i])
                    pick = i;
            if (pick < 0) begin
                // Directory full: evict the oldest, lowest index on ties.
                pick = 0;
                for (int i = 1; i < ENTRIES; i++)
                    if (age[i] > age[pick])
                        pick = i;
                if (dirt[pick]) begin
                    r.wbv = 1'b1;
                    r.wbb = tag[pick];
                end
            end
            occ[pick]  = 1'b1;
            dirt[pick] = 1'b0;
            tag[pick]  = b;
            age[pick]  = '0;
            r.idx = EIDX_W'(pick);
        end else begin
            for (int i = ENTRIES - 1; i >= 0; i--)
                if (occ[i] && tag[i] == b)
                    pick = i;
            if (pick < 0) begin
                r.status = STS_NOTINBUF;
            end else begin
                if (o == OP_DIRTY)
                    dirt[pick] = 1'b1;
                r.idx = EIDX_W'(pick);
            end
        end
        return r;
    endfunction

    // Present one word, hold it until the block takes it, then log what the
    // block owes and draw the gap before the next word.
    task automatic issue(input logic [OP_W-1:0] o, input logic [TAG_W-1:0] b,
                         input logic known, input dir_result_t typed);
        dir_result_t want;
        int gap;
        op <= o;
        block_number <= b;
        start <= 1'b1;
        // A word is taken at the edge where start is high and busy is low.
        do
            @(posedge clk);
        while (busy);
        want = apply_word(o, b);
        pending_results.push_back(known ? typed : want);
        n_words++;
        if (want.status == STS_OUTOFBOUND)
            n_oob++;
        else if (want.status == STS_NOTINBUF)
            n_misses++;
        else if (o == OP_ALLOC)
            n_allocs++;
        else if (o != OP_TICK)
            n_hits++;
        if (want.wbv)
            n_writebacks++;
        // Now and then switch between gap-free stretches and random gaps.
        if ($urandom_range(0, 63) == 0)
            no_gaps = ~no_gaps;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        // With no gap, keep start high: the next call drives the next word.
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Random words, weighted toward blocks already held so that lookups and
    // dirty marks hit, evictions find dirty entries and duplicates occur.
    task automatic run_random(input int count);
        logic [OP_W-1:0] o;
        logic [TAG_W-1:0] b;
        int pct;
        int k;
        for (int n = 0; n < count; n++) begin
            pct = $urandom_range(0, 99);
            if (pct < 35)
                o = OP_ALLOC;
            else if (pct < 60)
                o = OP_LOOKUP;
            else if (pct < 80)
                o = OP_DIRTY;
            else
                o = OP_TICK;
            pct = $urandom_range(0, 99);
            k = $urandom_range(0, ENTRIES - 1);
            if (o == OP_TICK || pct < 8)
                b = TAG_W'($urandom_range(DISK_SIZE, 65535));
            else if (pct < 55 && occ[k])
                b = tag[k];
            else if (pct < 75)
                b = TAG_W'($urandom_range(0, 15));
            else
                b = TAG_W'($urandom_range(0, DISK_SIZE - 1));
            // Tick ignores the block number: give it any 16-bit value.
            if (o == OP_TICK && pct < 50)
                b = TAG_W'($urandom_range(0, 65535));
            issue(o, b, 1'b0, '0);
        end
    endtask

    task automatic report_field(input string name, input logic [31:0] exp_v,
                                input logic [31:0] got_v);
        if (exp_v !== got_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $realtime, name, exp_v, got_v);
        end
    endtask

    always #6 clk = ~clk;

    // Watchdog: end the run if it stalls.
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Check every result word against the oldest one owed.
    always @(posedge clk) begin
        if (rst_n && done) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, actual status %0d index %0d",
                         $realtime, status, entry_index);
            end else begin
                report_field("status", 32'(pending_results[0].status), 32'(status));
                report_field("entry_index", 32'(pending_results[0].idx),
                             32'(entry_index));
                report_field("writeback_valid", 32'(pending_results[0].wbv),
                             32'(writeback_valid));
                report_field("writeback_block", 32'(pending_results[0].wbb),
                             32'(writeback_block));
                void'(pending_results.pop_front());
            end
        end
    end

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        op = OP_TICK;
        block_number = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            occ[i]  = 1'b0;
            dirt[i] = 1'b0;
            tag[i]  = '1;
            age[i]  = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed plan.
        for (int r = 0; r < PLAN_ROWS; r++)
            issue(plan[r].op, plan[r].blk, plan[r].known, plan[r].res);

        run_random(RANDOM_WORDS);
        start <= 1'b0;

        // Drain, then allow a search time for any stray result to show.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (ENTRIES + 8) @(posedge clk);

        $display("Sent %0d words: %0d allocations, %0d dirty write-backs,",
                 n_words, n_allocs, n_writebacks);
        $display("  %0d lookup/set-dirty hits, %0d misses, %0d out of bound.",
                 n_hits, n_misses, n_oob);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
